// File: rtl/dtmf_pkg.sv
package dtmf_pkg;

	localparam int SampleRate  = 8000;
	localparam int SineEntries = 256;
	localparam int IdxW        = $clog2(SineEntries);

	localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
	localparam logic [16:0] EnvFull   = 17'd65536;

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 20;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TONE_SAMPLES = 2'd0,
		CFG_RAMP_SAMPLES = 2'd1,
		CFG_RAMP_STEP    = 2'd2,
		CFG_AMPLITUDE    = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic       start_req;
		logic [3:0] digit;
	} in_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               active;
		logic               last;
	} out_t;

	typedef logic signed [15:0] sine_tab_t [SineEntries];
	typedef logic [31:0] step_tab_t [8];

	function automatic logic [31:0] step_of(input logic [63:0] f);
		logic [63:0] num;
		num = (f << 32) + 64'(SampleRate / 2);
		return 32'(num / SampleRate);
	endfunction

	function automatic logic signed [15:0] quarter_sine(input logic [63:0] u);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		x    = (u * HalfPiQ30 + 64'(SineEntries / 2)) / SineEntries;
		x2   = (x * x) >> 30;
		sum  = longint'(x);
		term = ((x * x2) >> 30) / 6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 110;
		sum  = sum - longint'(term);
		if (sum < 0)
			sum = 0;
		sum = (sum + 16384) >>> 15;
		if (sum > 32767)
			sum = 32767;
		return 16'(sum);
	endfunction

	function automatic sine_tab_t build_sine();
		sine_tab_t          tab;
		logic [63:0]        p;
		logic [63:0]        q;
		logic [63:0]        r;
		logic signed [15:0] v;
		for (int k = 0; k < SineEntries; k++) begin
			p = 64'(4 * k);
			q = p / SineEntries;
			r = p % SineEntries;
			v = q[0] ? quarter_sine(64'(SineEntries) - r) : quarter_sine(r);
			tab[k] = q[1] ? -v : v;
		end
		return tab;
	endfunction

	localparam sine_tab_t SineTable = build_sine();

	localparam step_tab_t FreqStepTable = '{
		step_of(64'd697),  step_of(64'd770),  step_of(64'd852),  step_of(64'd941),
		step_of(64'd1209), step_of(64'd1336), step_of(64'd1477), step_of(64'd1633)
	};

endpackage

// File: rtl/dtmf_tone_generator.sv
// Channel   Signals                      Payload
// input     in_valid / in_ready          in_data  (start_req, digit)
// output    out_valid / out_ready        out_data (sample, active, last)
// config    cfg_we, cfg_index            cfg_data (write only, no wait)
//
// A tone sample runs the sequencer through envelope update, sine table read and two passes
// of one shared 32x18 multiplier; the done state writes the result to the output register.
// An idle tick skips the table read and multiplies and goes from S_ENV straight to S_DONE.
// The input is ready only while the sequencer is idle, so one input is taken at a time.
// A result waits in the output register, and the next result holds the sequencer until the
// register is free. Reset is asynchronous and needs no clearing pass.
module dtmf_tone_generator import dtmf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_t                 in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_t                out_data,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ENV  = 6'b000010,
		S_READ = 6'b000100,
		S_MUL1 = 6'b001000,
		S_MUL2 = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;

	logic [19:0] tone_samples_q;
	logic [19:0] ramp_samples_q;
	logic [16:0] ramp_step_q;
	logic [13:0] amplitude_q;

	logic [31:0] low_phase_q;
	logic [31:0] high_phase_q;
	logic [31:0] low_step_q;
	logic [31:0] high_step_q;
	logic [19:0] sample_count_q;
	logic [16:0] envelope_q;
	logic        tone_active_q;

	logic [IdxW-1:0]    idx_low_q;
	logic [IdxW-1:0]    idx_high_q;
	logic signed [16:0] sinsum_q;
	logic signed [49:0] prod_q;
	logic               zero_q;
	logic               last_q;

	out_t out_q;
	logic out_valid_q;

	logic               rise;
	logic               fall;
	logic signed [18:0] env_sum;
	logic [16:0]        env_next;
	logic               last_next;
	logic [63:0]        wide_low;
	logic [63:0]        wide_high;
	logic signed [31:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [49:0] mul_p;
	logic [49:0]        mag;
	logic [18:0]        mag_sh;
	logic signed [15:0] sample_val;
	logic               out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		rise = ({1'b0, sample_count_q} + {1'b0, ramp_samples_q}) < {1'b0, tone_samples_q};
		fall = sample_count_q > ramp_samples_q;
		env_sum = $signed({2'b00, envelope_q})
			+ (rise ? $signed({2'b00, ramp_step_q}) : 19'sd0)
			- (fall ? $signed({2'b00, ramp_step_q}) : 19'sd0);
		if (env_sum < 19'sd0)
			env_next = '0;
		else if (env_sum > $signed({2'b00, EnvFull}))
			env_next = EnvFull;
		else
			env_next = env_sum[16:0];
		last_next = ({1'b0, sample_count_q} + 21'd1) >= {1'b0, tone_samples_q};
		wide_low  = {32'b0, low_phase_q} * 64'(SineEntries);
		wide_high = {32'b0, high_phase_q} * 64'(SineEntries);
	end

	always_comb begin
		if (state_q == S_MUL2) begin
			mul_a = prod_q[31:0];
			mul_b = {sinsum_q[16], sinsum_q};
		end else begin
			mul_a = $signed({15'b0, envelope_q});
			mul_b = $signed({4'b0, amplitude_q});
		end
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		mag    = prod_q[49] ? 50'(-prod_q) : 50'(prod_q);
		mag_sh = mag[49:31];
		if (zero_q)
			sample_val = '0;
		else if (prod_q[49])
			sample_val = (mag_sh >= 19'd32768) ? -16'sd32768 : 16'(-$signed(mag_sh));
		else
			sample_val = (mag_sh > 19'd32767) ? 16'sd32767 : 16'(mag_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_samples_q <= 20'd7466;
			ramp_samples_q <= 20'd149;
			ramp_step_q    <= 17'd440;
			amplitude_q    <= 14'd8000;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_TONE_SAMPLES: tone_samples_q <= cfg_data;
				CFG_RAMP_SAMPLES: ramp_samples_q <= cfg_data;
				CFG_RAMP_STEP:    ramp_step_q    <= cfg_data[16:0];
				CFG_AMPLITUDE:    amplitude_q    <= cfg_data[13:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			low_phase_q    <= '0;
			high_phase_q   <= '0;
			low_step_q     <= '0;
			high_step_q    <= '0;
			sample_count_q <= '0;
			envelope_q     <= '0;
			tone_active_q  <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_data.start_req) begin
							low_step_q     <= FreqStepTable[{1'b0, in_data.digit[3:2]}];
							high_step_q    <= FreqStepTable[{1'b1, in_data.digit[1:0]}];
							low_phase_q    <= '0;
							high_phase_q   <= '0;
							sample_count_q <= '0;
							envelope_q     <= '0;
							tone_active_q  <= 1'b1;
						end
						state_q <= S_ENV;
					end
				end
				S_ENV: begin
					if (!tone_active_q) begin
						state_q <= S_DONE;
					end else begin
						envelope_q     <= env_next;
						low_phase_q    <= low_phase_q + low_step_q;
						high_phase_q   <= high_phase_q + high_step_q;
						sample_count_q <= sample_count_q + 20'd1;
						if (last_next)
							tone_active_q <= 1'b0;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_DONE;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_ENV: begin
				zero_q     <= !tone_active_q;
				last_q     <= last_next;
				idx_low_q  <= wide_low[32 +: IdxW];
				idx_high_q <= wide_high[32 +: IdxW];
			end
			S_READ: begin
				sinsum_q <= 17'(SineTable[idx_low_q]) + 17'(SineTable[idx_high_q]);
			end
			S_MUL1, S_MUL2: begin
				prod_q <= mul_p;
			end
			S_DONE: begin
				if (out_free) begin
					out_q.sample <= sample_val;
					out_q.active <= !zero_q;
					out_q.last   <= !zero_q && last_q;
				end
			end
			default: ;
		endcase
	end

endmodule
